/* rtl/sha256_pkg.sv */
// Shared types, command/status structs and SHA-256 constant tables.
`default_nettype none

package sha256_pkg;

  localparam logic REQ_DATA   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAD80,
    S_PADZ,
    S_PADLEN,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BSEL_MSG,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift_en;
    byte_sel_t byte_sel;
    logic      latch_len;
    logic      load_work;
    logic      round_en;
    logic      fold;
    logic      clear;
    logic [5:0] step;
  } cmd_t;

  typedef struct packed {
    logic block_last;
    logic len_pos;
  } status_t;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h428a2f98;
      6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;
      6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;
      6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;
      6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;
      6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;
      6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;
      6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;
      6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;
      6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;
      6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;
      6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;
      6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;
      6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;
      6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;
      6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;
      6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;
      6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;
      6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;
      6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;
      6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;
      6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;
      6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;
      6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;
      6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;
      6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;
      6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;
      6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;
      6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;
      6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;
      6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;
      6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;
      default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/sha256_datapath.sv */
// Datapath: block shift line, message schedule, round unit, chaining state, length.
`default_nettype none

module sha256_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          data_byte,
  input  wire sha256_pkg::cmd_t    cmd,
  output sha256_pkg::status_t      status,
  output logic [31:0]              digest_word
);

  logic [31:0]  hash [8];
  logic [31:0]  work [8];
  logic [511:0] window;
  logic [5:0]   byte_count;
  logic [54:0]  blk_count;
  logic [63:0]  len_reg;

  logic [7:0]   byte_in;
  logic [5:0]   len_pos;
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // length bytes go out most significant first
  assign len_pos = {3'd7 - cmd.step[2:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      sha256_pkg::BSEL_MSG:  byte_in = data_byte;
      sha256_pkg::BSEL_PAD:  byte_in = 8'h80;
      sha256_pkg::BSEL_ZERO: byte_in = 8'h00;
      sha256_pkg::BSEL_LEN:  byte_in = len_reg[len_pos +: 8];
      default:               byte_in = 8'h00;
    endcase
  end

  // window word 0 is the oldest: w[t]; words 1, 9, 14 give w[t+16]
  assign w_new = small_s1(window[63:32]) + window[223:192] +
                 small_s0(window[479:448]) + window[511:480];

  assign t1 = work[7] + big_s1(work[4]) +
              ((work[4] & work[5]) ^ (~work[4] & work[6])) +
              sha256_pkg::round_k(cmd.step) + window[511:480];
  assign t2 = big_s0(work[0]) +
              ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      window <= {window[503:0], byte_in};
    end else if (cmd.round_en) begin
      window <= {window[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) begin
        work[i] <= hash[i];
      end
    end else if (cmd.round_en) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sha256_pkg::init_hash(3'(i));
      end
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + work[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      byte_count <= '0;
      blk_count  <= '0;
    end else if (cmd.shift_en) begin
      byte_count <= byte_count + 6'd1;
      if (byte_count == 6'd63) begin
        blk_count <= blk_count + 55'd1;
      end
    end
  end

  // compressed blocks are whole multiples of 512 bits
  always_ff @(posedge clk) begin
    if (cmd.latch_len) begin
      len_reg <= {blk_count, byte_count, 3'b000};
    end
  end

  assign status.block_last = (byte_count == 6'd63);
  assign status.len_pos    = (byte_count == 6'd56);
  assign digest_word       = hash[cmd.step[2:0]];

endmodule

`default_nettype wire

/* rtl/sha256_ctrl.sv */
// Controller: sequences absorb, padding, compression rounds and digest output.
`default_nettype none

module sha256_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                req_type,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               word_index,
  output logic                     last_word,
  input  wire sha256_pkg::status_t status,
  output sha256_pkg::cmd_t         cmd
);

  sha256_pkg::state_t state;
  sha256_pkg::state_t state_next;
  sha256_pkg::state_t ret;
  sha256_pkg::state_t ret_next;
  logic [5:0]         step;
  logic [5:0]         step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::S_IDLE;
      ret   <= sha256_pkg::S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      sha256_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == sha256_pkg::REQ_DATA) begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = sha256_pkg::BSEL_MSG;
            if (status.block_last) begin
              state_next = sha256_pkg::S_LOAD;
              ret_next   = sha256_pkg::S_IDLE;
            end
          end else begin
            cmd.latch_len = 1'b1;
            state_next    = sha256_pkg::S_PAD80;
          end
        end
      end
      sha256_pkg::S_PAD80: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = sha256_pkg::BSEL_PAD;
        if (status.block_last) begin
          state_next = sha256_pkg::S_LOAD;
          ret_next   = sha256_pkg::S_PADZ;
        end else begin
          state_next = sha256_pkg::S_PADZ;
        end
      end
      sha256_pkg::S_PADZ: begin
        if (status.len_pos) begin
          state_next = sha256_pkg::S_PADLEN;
          step_next  = '0;
        end else begin
          cmd.shift_en = 1'b1;
          cmd.byte_sel = sha256_pkg::BSEL_ZERO;
          if (status.block_last) begin
            state_next = sha256_pkg::S_LOAD;
            ret_next   = sha256_pkg::S_PADZ;
          end
        end
      end
      sha256_pkg::S_PADLEN: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = sha256_pkg::BSEL_LEN;
        step_next    = step + 6'd1;
        if (step[2:0] == 3'd7) begin
          state_next = sha256_pkg::S_LOAD;
          ret_next   = sha256_pkg::S_EMIT;
        end
      end
      sha256_pkg::S_LOAD: begin
        cmd.load_work = 1'b1;
        step_next     = '0;
        state_next    = sha256_pkg::S_ROUND;
      end
      sha256_pkg::S_ROUND: begin
        cmd.round_en = 1'b1;
        step_next    = step + 6'd1;
        if (step == 6'd63) begin
          state_next = sha256_pkg::S_FOLD;
        end
      end
      sha256_pkg::S_FOLD: begin
        cmd.fold   = 1'b1;
        step_next  = '0;
        state_next = ret;
      end
      sha256_pkg::S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          step_next = step + 6'd1;
          // last word taken: drop back to the initial chaining state
          if (step[2:0] == 3'd7) begin
            cmd.clear  = 1'b1;
            step_next  = '0;
            state_next = sha256_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = sha256_pkg::S_IDLE;
      end
    endcase
  end

  assign word_index = step[2:0];
  assign last_word  = (step[2:0] == 3'd7);

endmodule

`default_nettype wire

/* rtl/sha256_stream_hasher.sv */
// Top level of the byte-serial SHA-256 hasher: controller, datapath and checks.
`default_nettype none

// SHA-256 over a byte stream. Each data request (req_type 0) appends data_byte
// to the current 64-byte block; the 64th byte of a block starts a compression
// (load, 64 rounds on the single round unit, fold), during which in_ready is
// low. A finish request (req_type 1) pads one byte per cycle outside the
// compressions (0x80, zeros to byte 56, eight length bytes), runs one or two
// compressions, then presents the eight digest words, word_index 0 (most
// significant) first, last_word on the eighth; a finish takes longest when 56
// bytes of the block are held and a second block is padded. After the eighth
// word is taken the chaining state returns to the initial values and the next
// message may start. Input and output are not taken at the same time:
// in_ready stays low while digest words are offered.
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  sha256_pkg::cmd_t    cmd;
  sha256_pkg::status_t status;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_index (word_index),
    .last_word  (last_word),
    .status     (status),
    .cmd        (cmd)
  );

  sha256_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .status       (status),
    .digest_word  (digest_word)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output offered in the same cycle");

  a_word_advance: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=>
      out_valid && (word_index == 3'($past(word_index) + 3'd1)))
    else $error("digest word sequence broken");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> in_ready && !out_valid)
    else $error("block not idle after final digest word");

  a_digest_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(digest_word))
    else $error("digest word changed while stalled");

endmodule

`default_nettype wire
